/* hw/rtl/sd_spi_mode_host_engine_top_macros.svh */
// Assertion macros used by the checker file.
`ifndef SD_SPI_MODE_HOST_ENGINE_TOP_MACROS_SVH
`define SD_SPI_MODE_HOST_ENGINE_TOP_MACROS_SVH
`define SDH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdh check failed");
`define SDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdh check failed");
`endif

/* hw/rtl/sdh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sdh_pkg;
	localparam int SECTOR_BYTES = 512;
	localparam int REGISTER_BYTES = 16;
	localparam int WAKE_BYTES = 10;
	localparam int CNT_W = 10;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAKE, PH_FRAME, PH_R1, PH_TAIL, PH_GAP, PH_DRAIN, PH_TOKEN,
		PH_DATA, PH_CRC, PH_WTOK, PH_WDATA, PH_WCRC, PH_WBUSY
	} phase_t;

	localparam logic [2:0] FN_SLOT = 3'd0;
	localparam logic [2:0] FN_INIT = 3'd1;
	localparam logic [2:0] FN_RDSEC = 3'd2;
	localparam logic [2:0] FN_WRSEC = 3'd3;
	localparam logic [2:0] FN_CID = 3'd4;
	localparam logic [2:0] FN_CSD = 3'd5;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_RESP_TO = 3'd1;
	localparam logic [2:0] ST_DATA_ERR = 3'd2;
	localparam logic [2:0] ST_TOKEN_TO = 3'd3;
	localparam logic [2:0] ST_INIT_FAIL = 3'd4;

	localparam logic [1:0] REG_RESP = 2'd0;
	localparam logic [1:0] REG_TOKEN = 2'd1;
	localparam logic [1:0] REG_RETRY = 2'd2;

	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_SEND_CSD = 6'd9;
	localparam logic [5:0] CMD_SEND_CID = 6'd10;
	localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
	localparam logic [5:0] CMD_WRITE_BLOCK = 6'd24;
	localparam logic [5:0] CMD_APP_OP_COND = 6'd41;
	localparam logic [5:0] CMD_APP = 6'd55;
	localparam logic [5:0] CMD_READ_OCR = 6'd58;

	localparam logic [1:0] CARD_NONE = 2'd0;
	localparam logic [1:0] CARD_MMC = 2'd1;
	localparam logic [1:0] CARD_SDSC = 2'd2;
	localparam logic [1:0] CARD_SDHC = 2'd3;

	typedef struct packed {
		logic [2:0] func;
		logic [31:0] lba;
		logic [7:0] miso_byte;
		logic [7:0] write_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] mosi_byte;
		logic cs_active;
		logic [7:0] read_byte;
		logic read_valid;
		logic write_taken;
		logic busy_res;
		logic done_res;
		logic [2:0] status;
		logic [1:0] card_type;
		logic [15:0] data_crc;
	} out_item_t;
endpackage
`default_nettype wire

/* hw/rtl/sd_spi_mode_host_engine_top.sv */
// SPI-mode SD card host sequencer. Each input transaction is one bus byte slot: it carries the
// MISO byte returned by the previous exchange and an optional request (init, sector read or
// write, CID or CSD read); each gives exactly one result with the next MOSI byte and the chip
// select level. An item is taken each unstalled cycle: the state update is one registered pass
// and the result sits in an output register that keeps accepting while its content is taken
// in the same cycle. Requests arriving while an operation runs are ignored. Configuration (poll
// and retry limits) is written through its own valid/ready port at any time and is always ready.
`timescale 1ns / 1ps
`default_nettype none
module sd_spi_mode_host_engine_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire sdh_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output sdh_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	logic [15:0] resp_lim_q, tok_lim_q, retry_lim_q;
	sdh_pkg::phase_t phase_q, phase_d;
	logic [2:0] op_q, op_d;
	logic [sdh_pkg::CNT_W-1:0] bc_q, bc_d;
	logic [15:0] poll_q, poll_d, att_q, att_d, crc_q, crc_d;
	logic [47:0] frame_q, frame_d;
	logic [7:0] lr_q, lr_d, ocr_q, ocr_d;
	logic [1:0] run_q, run_d, kind_q, kind_d;
	logic [31:0] sec_q, sec_d;
	sdh_pkg::out_item_t res;
	logic take;

	assign cfg_ready = 1'b1;
	assign in_stall = out_valid && out_stall;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_lim_q <= 16'd1000;
			tok_lim_q <= 16'd1000;
			retry_lim_q <= 16'd1000;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdh_pkg::REG_RESP: resp_lim_q <= cfg_data;
				sdh_pkg::REG_TOKEN: tok_lim_q <= cfg_data;
				sdh_pkg::REG_RETRY: retry_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [7:0] fbyte(input logic [47:0] f, input logic [2:0] i);
		logic [7:0] b;
		case (i)
			3'd0: b = f[47:40];
			3'd1: b = f[39:32];
			3'd2: b = f[31:24];
			3'd3: b = f[23:16];
			3'd4: b = f[15:8];
			default: b = f[7:0];
		endcase
		return b;
	endfunction

	always_comb begin
		logic [5:0] cmd;
		logic [7:0] miso;
		logic [15:0] pinc;
		logic [1:0] rnext;
		logic [sdh_pkg::CNT_W:0] len;
		logic fin, gp, ar1, bcmd;
		logic [2:0] st;
		logic [5:0] ncmd;
		logic [31:0] narg;
		logic [7:0] ncrc;
		cmd = frame_q[45:40];
		miso = in_data.miso_byte;
		len = (cmd == sdh_pkg::CMD_READ_BLOCK) ? (sdh_pkg::CNT_W+1)'(sdh_pkg::SECTOR_BYTES)
			: (sdh_pkg::CNT_W+1)'(sdh_pkg::REGISTER_BYTES);
		pinc = (poll_q != 16'hFFFF) ? poll_q + 16'd1 : poll_q;
		rnext = '0;
		phase_d = phase_q; op_d = op_q; bc_d = bc_q; poll_d = poll_q; att_d = att_q;
		crc_d = crc_q; frame_d = frame_q; lr_d = lr_q; ocr_d = ocr_q; run_d = run_q;
		kind_d = kind_q; sec_d = sec_q;
		res = '0;
		res.mosi_byte = 8'hFF;
		fin = 1'b0; gp = 1'b0; ar1 = 1'b0; bcmd = 1'b0; st = sdh_pkg::ST_OK;
		ncmd = '0; narg = '0; ncrc = '0;
		case (phase_q)
			sdh_pkg::PH_IDLE: begin
				if (in_data.func inside {[sdh_pkg::FN_INIT:sdh_pkg::FN_CSD]}) begin
					op_d = in_data.func;
					crc_d = '0;
				end
				case (in_data.func)
					sdh_pkg::FN_INIT: begin
						kind_d = sdh_pkg::CARD_NONE; att_d = '0; bc_d = '0;
						phase_d = sdh_pkg::PH_WAKE;
					end
					sdh_pkg::FN_RDSEC: begin
						sec_d = in_data.lba; bcmd = 1'b1; ncmd = sdh_pkg::CMD_READ_BLOCK;
						narg = in_data.lba;
					end
					sdh_pkg::FN_WRSEC: begin
						sec_d = in_data.lba; bcmd = 1'b1; ncmd = sdh_pkg::CMD_WRITE_BLOCK;
						narg = in_data.lba;
					end
					sdh_pkg::FN_CID: begin bcmd = 1'b1; ncmd = sdh_pkg::CMD_SEND_CID; end
					sdh_pkg::FN_CSD: begin bcmd = 1'b1; ncmd = sdh_pkg::CMD_SEND_CSD; end
					default: ;
				endcase
			end
			sdh_pkg::PH_WAKE: begin
				if (bc_q < sdh_pkg::CNT_W'(sdh_pkg::WAKE_BYTES)) bc_d = bc_q + 1'b1;
				else begin bcmd = 1'b1; ncmd = sdh_pkg::CMD_GO_IDLE; ncrc = 8'h95; end
			end
			sdh_pkg::PH_FRAME: begin
				res.cs_active = 1'b1;
				if (bc_q < sdh_pkg::CNT_W'(6)) begin
					res.mosi_byte = fbyte(frame_q, bc_q[2:0]);
					bc_d = bc_q + 1'b1;
				end else begin
					poll_d = '0; phase_d = sdh_pkg::PH_R1;
				end
			end
			sdh_pkg::PH_R1: begin
				res.cs_active = 1'b1;
				poll_d = pinc;
				if (!miso[7]) begin lr_d = miso; ar1 = 1'b1; end
				else if (pinc >= resp_lim_q) begin lr_d = 8'hFF; ar1 = 1'b1; end
			end
			sdh_pkg::PH_TAIL: begin
				bc_d = bc_q + 1'b1;
				if (cmd == sdh_pkg::CMD_READ_OCR && bc_d == sdh_pkg::CNT_W'(1)) ocr_d = miso;
				if (bc_d < sdh_pkg::CNT_W'(4)) res.cs_active = 1'b1;
				else if (cmd == sdh_pkg::CMD_IF_COND) begin
					if (lr_q == 8'hFF) begin fin = 1'b1; st = sdh_pkg::ST_RESP_TO; end
					else if (lr_q[2]) begin kind_d = sdh_pkg::CARD_MMC; fin = 1'b1; end
					else gp = 1'b1;
				end else if (att_q == '0) begin
					if (lr_q == 8'hFF) begin fin = 1'b1; st = sdh_pkg::ST_RESP_TO; end
					else gp = 1'b1;
				end else begin
					kind_d = ocr_q[6] ? sdh_pkg::CARD_SDHC : sdh_pkg::CARD_SDSC;
					fin = 1'b1;
				end
			end
			sdh_pkg::PH_GAP: begin
				bcmd = 1'b1;
				if (cmd == sdh_pkg::CMD_GO_IDLE) begin
					ncmd = sdh_pkg::CMD_IF_COND; narg = 32'h1AA; ncrc = 8'h87;
				end else if (cmd == sdh_pkg::CMD_IF_COND) ncmd = sdh_pkg::CMD_READ_OCR;
				else if (cmd == sdh_pkg::CMD_APP) begin
					ncmd = sdh_pkg::CMD_APP_OP_COND; narg = 32'h40000000; ncrc = 8'hFF;
				end else if (cmd == sdh_pkg::CMD_APP_OP_COND && lr_q == 8'h00)
					ncmd = sdh_pkg::CMD_READ_OCR;
				else if (cmd == sdh_pkg::CMD_READ_OCR || cmd == sdh_pkg::CMD_APP_OP_COND) begin
					ncmd = sdh_pkg::CMD_APP;
					if (att_q != 16'hFFFF) att_d = att_q + 16'd1;
				end else begin
					bcmd = 1'b0; phase_d = sdh_pkg::PH_IDLE;
				end
			end
			sdh_pkg::PH_DRAIN: begin
				rnext = (miso == 8'hFF) ? ((run_q < 2'd2) ? run_q + 2'd1 : run_q) : 2'd0;
				run_d = rnext;
				if (rnext < 2'd2) res.cs_active = 1'b1;
				else if (lr_q == 8'h00) gp = 1'b1;
				else if (att_q >= retry_lim_q) begin fin = 1'b1; st = sdh_pkg::ST_INIT_FAIL; end
				else gp = 1'b1;
			end
			sdh_pkg::PH_TOKEN: begin
				poll_d = pinc;
				if (miso == 8'hFE) begin
					res.cs_active = 1'b1; bc_d = '0; phase_d = sdh_pkg::PH_DATA;
				end else if (miso[7:5] == 3'b000) begin fin = 1'b1; st = sdh_pkg::ST_DATA_ERR; end
				else if (pinc >= tok_lim_q) begin fin = 1'b1; st = sdh_pkg::ST_TOKEN_TO; end
				else res.cs_active = 1'b1;
			end
			sdh_pkg::PH_DATA: begin
				res.cs_active = 1'b1; res.read_byte = miso; res.read_valid = 1'b1;
				if ({1'b0, bc_q} + 1'b1 >= len) begin bc_d = '0; phase_d = sdh_pkg::PH_CRC; end
				else bc_d = bc_q + 1'b1;
			end
			sdh_pkg::PH_CRC: begin
				if (bc_q == '0) begin
					crc_d = {miso, 8'h00}; bc_d = sdh_pkg::CNT_W'(1); res.cs_active = 1'b1;
				end else begin
					crc_d = crc_q | {8'h00, miso}; fin = 1'b1;
				end
			end
			sdh_pkg::PH_WTOK: begin
				bc_d = '0; phase_d = sdh_pkg::PH_WDATA; res.mosi_byte = 8'hFE;
				res.cs_active = 1'b1;
			end
			sdh_pkg::PH_WDATA: begin
				res.mosi_byte = in_data.write_byte; res.cs_active = 1'b1; res.write_taken = 1'b1;
				if ({1'b0, bc_q} + 1'b1 >= (sdh_pkg::CNT_W+1)'(sdh_pkg::SECTOR_BYTES)) begin
					bc_d = '0; phase_d = sdh_pkg::PH_WCRC;
				end else bc_d = bc_q + 1'b1;
			end
			sdh_pkg::PH_WCRC: begin
				res.cs_active = 1'b1;
				if (bc_q >= sdh_pkg::CNT_W'(2)) phase_d = sdh_pkg::PH_WBUSY;
				else bc_d = bc_q + 1'b1;
			end
			sdh_pkg::PH_WBUSY: begin
				if (miso == 8'h00) res.cs_active = 1'b1;
				else fin = 1'b1;
			end
			default: phase_d = sdh_pkg::PH_IDLE;
		endcase
		// Dispatch on the command whose R1 has just arrived.
		if (ar1) begin
			case (cmd)
				sdh_pkg::CMD_GO_IDLE: begin
					if (lr_d == 8'hFF) begin fin = 1'b1; st = sdh_pkg::ST_RESP_TO; end
					else gp = 1'b1;
				end
				sdh_pkg::CMD_IF_COND, sdh_pkg::CMD_READ_OCR: begin
					bc_d = '0; phase_d = sdh_pkg::PH_TAIL; res.cs_active = 1'b1;
				end
				sdh_pkg::CMD_APP: gp = 1'b1;
				sdh_pkg::CMD_APP_OP_COND: begin
					run_d = '0; phase_d = sdh_pkg::PH_DRAIN; res.cs_active = 1'b1;
				end
				sdh_pkg::CMD_WRITE_BLOCK: begin
					phase_d = sdh_pkg::PH_WTOK; res.cs_active = 1'b1;
				end
				default: begin
					poll_d = '0; phase_d = sdh_pkg::PH_TOKEN; res.cs_active = 1'b1;
				end
			endcase
		end
		if (gp) begin
			res.mosi_byte = 8'hFF; res.cs_active = 1'b0; phase_d = sdh_pkg::PH_GAP;
		end
		if (bcmd) begin
			frame_d = {2'b01, ncmd, narg, ncrc};
			bc_d = sdh_pkg::CNT_W'(1);
			phase_d = sdh_pkg::PH_FRAME;
			res.mosi_byte = {2'b01, ncmd};
			res.cs_active = 1'b1;
		end
		if (fin) begin
			res.mosi_byte = 8'hFF; res.cs_active = 1'b0; res.done_res = 1'b1; res.status = st;
			if (op_q == sdh_pkg::FN_RDSEC || op_q == sdh_pkg::FN_CID || op_q == sdh_pkg::FN_CSD)
				res.data_crc = crc_d;
			phase_d = sdh_pkg::PH_IDLE;
		end
		res.busy_res = (phase_d != sdh_pkg::PH_IDLE);
		res.card_type = kind_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdh_pkg::PH_IDLE; op_q <= '0; bc_q <= '0; poll_q <= '0; att_q <= '0;
			frame_q <= '0; lr_q <= 8'hFF; run_q <= '0; ocr_q <= '0; sec_q <= '0;
			kind_q <= sdh_pkg::CARD_NONE; crc_q <= '0; out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d; op_q <= op_d; bc_q <= bc_d; poll_q <= poll_d;
				att_q <= att_d; frame_q <= frame_d; lr_q <= lr_d; run_q <= run_d;
				ocr_q <= ocr_d; sec_q <= sec_d; kind_q <= kind_d; crc_q <= crc_d;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_data <= res;
	end
endmodule
`default_nettype wire

/* hw/rtl/sdh_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "sd_spi_mode_host_engine_top_macros.svh"
module sdh_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire sdh_pkg::out_item_t out_data
);
	// An accepted input always yields a result in the next cycle.
	`SDH_ASSERT_NEXT(a_item_result, clk, arst_n, in_valid && !in_stall, out_valid)
	// A finished operation leaves the card deselected and the block idle.
	`SDH_ASSERT_IMPL(a_done_idle, clk, arst_n, out_valid && out_data.done_res,
		!out_data.cs_active && !out_data.busy_res)
	// Status codes other than success only appear with completion.
	`SDH_ASSERT_IMPL(a_status_done, clk, arst_n, out_valid && out_data.status != sdh_pkg::ST_OK,
		out_data.done_res)
	// Stalled results hold.
	`SDH_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))
endmodule
bind sd_spi_mode_host_engine_top sdh_checker u_sdh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

/* dv/tb_sd_spi_mode_host_engine_top.sv */
`timescale 1ns / 1ps
module tb_sd_spi_mode_host_engine_top;
	localparam int SLOT_TIMEOUT = 20000;
	localparam int ITEM_TARGET = 1900;

	class sd_slot_scoreboard;
		bit [15:0] resp_limit, token_limit, retry_limit;
		sdh_pkg::phase_t phase;
		bit [2:0] op_kind;
		bit [15:0] byte_cnt, poll_cnt, attempts, crc_hold;
		bit [47:0] frame;
		bit [7:0] last_r1, ocr_top;
		bit [1:0] idle_run, card_kind;
		bit [31:0] sector;
		sdh_pkg::out_item_t pending[$];
		sdh_pkg::out_item_t o;
		int errors, checked, reads, writes, inits, done_cnt;

		function new();
			resp_limit = 16'd1000; token_limit = 16'd1000; retry_limit = 16'd1000;
			phase = sdh_pkg::PH_IDLE; op_kind = '0; byte_cnt = '0; poll_cnt = '0;
			attempts = '0; frame = '0; last_r1 = 8'hFF; idle_run = '0; ocr_top = '0;
			sector = '0; card_kind = sdh_pkg::CARD_NONE; crc_hold = '0;
			errors = 0; checked = 0; reads = 0; writes = 0; inits = 0; done_cnt = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			if (idx == sdh_pkg::REG_RESP) resp_limit = val;
			else if (idx == sdh_pkg::REG_TOKEN) token_limit = val;
			else if (idx == sdh_pkg::REG_RETRY) retry_limit = val;
		endfunction

		function void emit(bit [7:0] m, bit cs);
			o.mosi_byte = m;
			o.cs_active = cs;
		endfunction

		function void finish(bit [2:0] st);
			emit(8'hFF, 1'b0);
			o.done_res = 1'b1;
			o.status = st;
			if (op_kind == sdh_pkg::FN_RDSEC || op_kind == sdh_pkg::FN_CID
				|| op_kind == sdh_pkg::FN_CSD)
				o.data_crc = crc_hold;
			phase = sdh_pkg::PH_IDLE;
			done_cnt++;
		endfunction

		function void gap();
			emit(8'hFF, 1'b0);
			phase = sdh_pkg::PH_GAP;
		endfunction

		function bit [7:0] frame_byte(int i);
			return frame[8 * (5 - (i % 6)) +: 8];
		endfunction

		function void issue_cmd(bit [5:0] c, bit [31:0] arg, bit [7:0] crc);
			frame = {2'b01, c, arg, crc};
			byte_cnt = 16'd1;
			phase = sdh_pkg::PH_FRAME;
			emit(frame_byte(0), 1'b1);
		endfunction

		function void next_attempt();
			if (attempts != 16'hFFFF) attempts++;
			issue_cmd(sdh_pkg::CMD_APP, 32'h0, 8'h00);
		endfunction

		function void after_r1();
			case (frame[45:40])
				sdh_pkg::CMD_GO_IDLE: begin
					if (last_r1 == 8'hFF) finish(sdh_pkg::ST_RESP_TO); else gap();
				end
				sdh_pkg::CMD_IF_COND, sdh_pkg::CMD_READ_OCR: begin
					byte_cnt = '0; phase = sdh_pkg::PH_TAIL; emit(8'hFF, 1'b1);
				end
				sdh_pkg::CMD_APP: gap();
				sdh_pkg::CMD_APP_OP_COND: begin
					idle_run = '0; phase = sdh_pkg::PH_DRAIN; emit(8'hFF, 1'b1);
				end
				sdh_pkg::CMD_WRITE_BLOCK: begin
					phase = sdh_pkg::PH_WTOK; emit(8'hFF, 1'b1);
				end
				default: begin
					poll_cnt = '0; phase = sdh_pkg::PH_TOKEN; emit(8'hFF, 1'b1);
				end
			endcase
		endfunction

		// Works out the one result caused by an accepted slot and queues it.
		function void note_slot(sdh_pkg::in_item_t it);
			bit [5:0] c;
			int len;
			c = frame[45:40];
			len = (c == sdh_pkg::CMD_READ_BLOCK) ? sdh_pkg::SECTOR_BYTES
				: sdh_pkg::REGISTER_BYTES;
			o = '0;
			o.mosi_byte = 8'hFF;
			case (phase)
				sdh_pkg::PH_IDLE: begin
					if (it.func >= sdh_pkg::FN_INIT && it.func <= sdh_pkg::FN_CSD) begin
						op_kind = it.func; crc_hold = '0;
					end
					if (it.func == sdh_pkg::FN_INIT) begin
						card_kind = sdh_pkg::CARD_NONE; attempts = '0; byte_cnt = '0;
						phase = sdh_pkg::PH_WAKE; emit(8'hFF, 1'b0); inits++;
					end else if (it.func == sdh_pkg::FN_RDSEC) begin
						sector = it.lba; issue_cmd(sdh_pkg::CMD_READ_BLOCK, sector, 8'h00);
						reads++;
					end else if (it.func == sdh_pkg::FN_WRSEC) begin
						sector = it.lba; issue_cmd(sdh_pkg::CMD_WRITE_BLOCK, sector, 8'h00);
						writes++;
					end else if (it.func == sdh_pkg::FN_CID)
						issue_cmd(sdh_pkg::CMD_SEND_CID, 32'h0, 8'h00);
					else if (it.func == sdh_pkg::FN_CSD)
						issue_cmd(sdh_pkg::CMD_SEND_CSD, 32'h0, 8'h00);
					else emit(8'hFF, 1'b0);
				end
				sdh_pkg::PH_WAKE: begin
					if (byte_cnt < sdh_pkg::WAKE_BYTES) begin
						byte_cnt++; emit(8'hFF, 1'b0);
					end else issue_cmd(sdh_pkg::CMD_GO_IDLE, 32'h0, 8'h95);
				end
				sdh_pkg::PH_FRAME: begin
					if (byte_cnt < 6) begin
						emit(frame_byte(byte_cnt), 1'b1); byte_cnt++;
					end else begin
						poll_cnt = '0; phase = sdh_pkg::PH_R1; emit(8'hFF, 1'b1);
					end
				end
				sdh_pkg::PH_R1: begin
					if (poll_cnt != 16'hFFFF) poll_cnt++;
					if (!it.miso_byte[7]) begin
						last_r1 = it.miso_byte; after_r1();
					end else if (poll_cnt >= resp_limit) begin
						last_r1 = 8'hFF; after_r1();
					end else emit(8'hFF, 1'b1);
				end
				sdh_pkg::PH_TAIL: begin
					byte_cnt++;
					if (c == sdh_pkg::CMD_READ_OCR && byte_cnt == 1) ocr_top = it.miso_byte;
					if (byte_cnt < 4) emit(8'hFF, 1'b1);
					else if (c == sdh_pkg::CMD_IF_COND) begin
						if (last_r1 == 8'hFF) finish(sdh_pkg::ST_RESP_TO);
						else if (last_r1[2]) begin
							card_kind = sdh_pkg::CARD_MMC; finish(sdh_pkg::ST_OK);
						end else gap();
					end else if (attempts == 0) begin
						if (last_r1 == 8'hFF) finish(sdh_pkg::ST_RESP_TO); else gap();
					end else begin
						card_kind = ocr_top[6] ? sdh_pkg::CARD_SDHC : sdh_pkg::CARD_SDSC;
						finish(sdh_pkg::ST_OK);
					end
				end
				sdh_pkg::PH_GAP: begin
					if (c == sdh_pkg::CMD_GO_IDLE)
						issue_cmd(sdh_pkg::CMD_IF_COND, 32'h1AA, 8'h87);
					else if (c == sdh_pkg::CMD_IF_COND)
						issue_cmd(sdh_pkg::CMD_READ_OCR, 32'h0, 8'h00);
					else if (c == sdh_pkg::CMD_READ_OCR) next_attempt();
					else if (c == sdh_pkg::CMD_APP)
						issue_cmd(sdh_pkg::CMD_APP_OP_COND, 32'h4000_0000, 8'hFF);
					else if (c == sdh_pkg::CMD_APP_OP_COND && last_r1 == 0)
						issue_cmd(sdh_pkg::CMD_READ_OCR, 32'h0, 8'h00);
					else if (c == sdh_pkg::CMD_APP_OP_COND) next_attempt();
					else begin
						phase = sdh_pkg::PH_IDLE; emit(8'hFF, 1'b0);
					end
				end
				sdh_pkg::PH_DRAIN: begin
					if (it.miso_byte == 8'hFF) begin
						if (idle_run < 2) idle_run++;
					end else idle_run = '0;
					if (idle_run < 2) emit(8'hFF, 1'b1);
					else if (last_r1 == 0) gap();
					else if (attempts >= retry_limit) finish(sdh_pkg::ST_INIT_FAIL);
					else gap();
				end
				sdh_pkg::PH_TOKEN: begin
					if (poll_cnt != 16'hFFFF) poll_cnt++;
					if (it.miso_byte == 8'hFE) begin
						byte_cnt = '0; phase = sdh_pkg::PH_DATA; emit(8'hFF, 1'b1);
					end else if ((it.miso_byte & 8'hE0) == 0) finish(sdh_pkg::ST_DATA_ERR);
					else if (poll_cnt >= token_limit) finish(sdh_pkg::ST_TOKEN_TO);
					else emit(8'hFF, 1'b1);
				end
				sdh_pkg::PH_DATA: begin
					o.read_byte = it.miso_byte; o.read_valid = 1'b1;
					if (byte_cnt + 1 >= len) begin
						byte_cnt = '0; phase = sdh_pkg::PH_CRC;
					end else byte_cnt++;
					emit(8'hFF, 1'b1);
				end
				sdh_pkg::PH_CRC: begin
					if (byte_cnt == 0) begin
						crc_hold = {it.miso_byte, 8'h00}; byte_cnt = 16'd1; emit(8'hFF, 1'b1);
					end else begin
						crc_hold[7:0] = crc_hold[7:0] | it.miso_byte; finish(sdh_pkg::ST_OK);
					end
				end
				sdh_pkg::PH_WTOK: begin
					byte_cnt = '0; phase = sdh_pkg::PH_WDATA; emit(8'hFE, 1'b1);
				end
				sdh_pkg::PH_WDATA: begin
					emit(it.write_byte, 1'b1); o.write_taken = 1'b1;
					if (byte_cnt + 1 >= sdh_pkg::SECTOR_BYTES) begin
						byte_cnt = '0; phase = sdh_pkg::PH_WCRC;
					end else byte_cnt++;
				end
				sdh_pkg::PH_WCRC: begin
					emit(8'hFF, 1'b1);
					if (byte_cnt >= 2) phase = sdh_pkg::PH_WBUSY; else byte_cnt++;
				end
				sdh_pkg::PH_WBUSY: begin
					if (it.miso_byte == 0) emit(8'hFF, 1'b1); else finish(sdh_pkg::ST_OK);
				end
				default: begin
					phase = sdh_pkg::PH_IDLE; emit(8'hFF, 1'b0);
				end
			endcase
			o.busy_res = (phase != sdh_pkg::PH_IDLE);
			o.card_type = card_kind;
			pending.push_back(o);
		endfunction

		function void check_result(sdh_pkg::out_item_t got);
			sdh_pkg::out_item_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.mosi_byte !== exp.mosi_byte)
				$display("%0t: mosi_byte expected %h actual %h", $time, exp.mosi_byte,
					got.mosi_byte);
			if (got.cs_active !== exp.cs_active)
				$display("%0t: cs_active expected %b actual %b", $time, exp.cs_active,
					got.cs_active);
			if (got.read_byte !== exp.read_byte)
				$display("%0t: read_byte expected %h actual %h", $time, exp.read_byte,
					got.read_byte);
			if (got.read_valid !== exp.read_valid)
				$display("%0t: read_valid expected %b actual %b", $time, exp.read_valid,
					got.read_valid);
			if (got.write_taken !== exp.write_taken)
				$display("%0t: write_taken expected %b actual %b", $time, exp.write_taken,
					got.write_taken);
			if (got.busy_res !== exp.busy_res)
				$display("%0t: busy_res expected %b actual %b", $time, exp.busy_res,
					got.busy_res);
			if (got.done_res !== exp.done_res)
				$display("%0t: done_res expected %b actual %b", $time, exp.done_res,
					got.done_res);
			if (got.status !== exp.status)
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
			if (got.card_type !== exp.card_type)
				$display("%0t: card_type expected %0d actual %0d", $time, exp.card_type,
					got.card_type);
			if (got.data_crc !== exp.data_crc)
				$display("%0t: data_crc expected %h actual %h", $time, exp.data_crc,
					got.data_crc);
			if (got !== exp) errors++;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	sdh_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1;
	sdh_pkg::out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	sd_slot_scoreboard sb = new();
	int quiet_cycles = 0;
	int hold_stretch = 0;
	int rx_wait = 0;
	int slot_count = 0;

	sd_spi_mode_host_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Receiver: after about one result in four it waits a drawn time; there is also one long hold.
	always @(posedge clk) begin : rx_side
		int n;
		if (arst_n) begin
			if (out_valid && !out_stall) sb.check_result(out_data);
			if (hold_stretch > 0) begin
				hold_stretch <= hold_stretch - 1;
				out_stall <= 1;
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				out_stall <= 1;
			end else if (out_valid && !out_stall) begin
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
				rx_wait <= (n > 0) ? n - 1 : 0;
				out_stall <= (n > 0);
			end else out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= SLOT_TIMEOUT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	bit quick_gaps = 0;

	// Valid stays up between back-to-back items; it drops when a gap is drawn or while draining.
	task automatic send_slot(logic [2:0] fn, logic [31:0] addr, logic [7:0] miso,
		logic [7:0] wb);
		int wait_n;
		sdh_pkg::in_item_t it;
		wait_n = quick_gaps ? 0 : ($urandom_range(0, 5) == 0 ? $urandom_range(0, 18) : 0);
		it = '{func: fn, lba: addr, miso_byte: miso, write_byte: wb};
		if (wait_n > 0) begin
			in_valid <= 0;
			repeat (wait_n) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_slot(it);
		slot_count++;
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Miso byte a cooperative card would give in the current phase, with occasional noise.
	function automatic logic [7:0] card_byte(int noise);
		if ($urandom_range(0, 99) < noise) return 8'($urandom_range(0, 255));
		case (sb.phase)
			sdh_pkg::PH_R1: begin
				if ($urandom_range(0, 2) == 0) return 8'hFF;
				if (sb.frame[45:40] == sdh_pkg::CMD_APP_OP_COND)
					return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'h01;
				if (sb.frame[45:40] == sdh_pkg::CMD_IF_COND)
					return ($urandom_range(0, 4) == 0) ? 8'h05 : 8'h01;
				return 8'($urandom_range(0, 1));
			end
			sdh_pkg::PH_DRAIN: return ($urandom_range(0, 3) != 0) ? 8'hFF : 8'h00;
			sdh_pkg::PH_TOKEN: begin
				case ($urandom_range(0, 9))
					0: return 8'h09;
					1, 2: return 8'hFF;
					default: return 8'hFE;
				endcase
			end
			sdh_pkg::PH_WBUSY: return ($urandom_range(0, 2) != 0) ? 8'h00 : 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic run_op(logic [2:0] fn, logic [31:0] addr, int noise);
		send_slot(fn, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		while (sb.phase != sdh_pkg::PH_IDLE) begin
			// Requests while busy must be ignored.
			send_slot(3'($urandom_range(0, 7)), $urandom, card_byte(noise),
				8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int k;
		int fn;
		int budget;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Short limits first so that timeouts are cheap.
		write_limit(sdh_pkg::REG_RESP, 16'd3);
		write_limit(sdh_pkg::REG_TOKEN, 16'd4);
		write_limit(sdh_pkg::REG_RETRY, 16'd2);
		send_slot(sdh_pkg::FN_SLOT, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		send_slot(3'd6, 32'h0, 8'h00, 8'h00);
		send_slot(3'd7, 32'hA5A5_5A5A, 8'h80, 8'h7F);
		run_op(sdh_pkg::FN_INIT, 32'h0, 0);
		run_op(sdh_pkg::FN_RDSEC, 32'hFFFF_FFFF, 0);
		run_op(sdh_pkg::FN_WRSEC, 32'h8000_0001, 0);
		run_op(sdh_pkg::FN_CID, 32'h0, 0);
		run_op(sdh_pkg::FN_CSD, 32'h0, 0);
		wait_drained();

		for (k = 0; k < 6; k++) begin
			if (k == 2) begin
				// Long receiver hold while items keep coming, so the input backs up.
				hold_stretch = 60;
				quick_gaps = 1;
			end
			if (k == 3) quick_gaps = 0;
			case (k)
				1: begin
					write_limit(sdh_pkg::REG_RESP, 16'd1);
					write_limit(sdh_pkg::REG_TOKEN, 16'd1);
					write_limit(sdh_pkg::REG_RETRY, 16'd1);
				end
				2: begin
					write_limit(sdh_pkg::REG_RESP, 16'd0);
					write_limit(sdh_pkg::REG_TOKEN, 16'd0);
				end
				3: begin
					write_limit(sdh_pkg::REG_RESP, 16'hFFFF);
					write_limit(sdh_pkg::REG_TOKEN, 16'hFFFF);
					write_limit(sdh_pkg::REG_RETRY, 16'hFFFF);
				end
				4: begin
					write_limit(sdh_pkg::REG_RESP, 16'd8);
					write_limit(sdh_pkg::REG_TOKEN, 16'd12);
					write_limit(sdh_pkg::REG_RETRY, 16'd5);
				end
				5: begin
					write_limit(sdh_pkg::REG_RESP, 16'd1000);
					write_limit(sdh_pkg::REG_TOKEN, 16'd1000);
					write_limit(sdh_pkg::REG_RETRY, 16'd0);
				end
				default: ;
			endcase
			// The remaining slot budget is shared evenly across the limit settings;
			// CID and CSD reads exercise the token and data path cheaply.
			budget = slot_count + (ITEM_TARGET - slot_count) / (6 - k);
			while (slot_count < budget) begin
				fn = $urandom_range(0, 11);
				if (fn == 0)
					send_slot(sdh_pkg::FN_SLOT, $urandom, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else if (fn <= 4)
					run_op(sdh_pkg::FN_INIT, $urandom, ($urandom_range(0, 1) != 0) ? 0 : 10);
				else if (fn <= 7)
					run_op(sdh_pkg::FN_CID, $urandom, ($urandom_range(0, 1) != 0) ? 0 : 10);
				else if (fn <= 10) run_op(sdh_pkg::FN_CSD, $urandom, 5);
				else
					send_slot(3'($urandom_range(6, 7)), $urandom, 8'($urandom_range(0, 255)),
						8'h00);
			end
			wait_drained();
		end

		k = 0;
		while (sb.pending.size() != 0 && k < SLOT_TIMEOUT) begin
			@(posedge clk);
			k++;
		end
		repeat (10) @(posedge clk);
		if (sb.pending.size() != 0) sb.errors++;
		$display("Covered %0d slots, %0d results checked: %0d inits, %0d reads, %0d writes,",
			slot_count, sb.checked, sb.inits, sb.reads, sb.writes);
		$display("%0d completed operations across six limit settings.", sb.done_cnt);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
